// ----- hdl/lrukv_pkg.sv -----
// shared widths, codes and constants of the lru key-value cache
package lrukv_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int CAP_W       = 5;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;

  localparam logic [CAP_W-1:0] CAPACITY_RST = 5'd16;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // all ones, i.e. -1 as a signed word
  localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

endpackage

// ----- hdl/lrukv_req_if.sv -----
// request channel: command, key and value with valid/ready
interface lrukv_req_if import lrukv_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [KEY_W-1:0] key;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink   (input valid, input cmd, input key, input value, output ready);

endinterface

// ----- hdl/lrukv_rsp_if.sv -----
// response channel: hit, read value and eviction report with valid/ready
interface lrukv_rsp_if import lrukv_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic signed [VAL_W-1:0] read_value;
  logic                    evicted;
  logic signed [KEY_W-1:0] evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);

endinterface

// ----- hdl/lru_key_value_cache.sv -----
// fully associative key-value cache with least-recently-used replacement
//
// One request word (get or put of a 32 bit key, plus a value for put) gives one
// response word. A request is held in an input register; the key is then
// compared against all ENTRIES entries at once, the recency ranks are updated
// and the response is loaded into the output register, from which the response
// word is offered. One request is taken every cycle: the rate is set by the
// compare-and-rank-update stage, and it holds as long as the response side
// takes its words. A put that misses on a full store replaces the entry of
// highest rank (least recent) and reports its key. The capacity register
// (1..ENTRIES, 0 acts as 1, larger values act as ENTRIES) is written through
// capacity_we/capacity_wdata; the user must write it only while the block is
// idle, the block itself does not enforce this. Every write empties the store.
// No clearing pass is needed after reset.
module lru_key_value_cache import lrukv_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  lrukv_req_if.sink        req,
  lrukv_rsp_if.source      rsp,
  input  logic             capacity_we,
  input  logic [CAP_W-1:0] capacity_wdata
);

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // configuration and store
  logic [CAP_W-1:0]        capacity;
  logic [ENTRIES-1:0]      entry_valid;
  logic signed [KEY_W-1:0] entry_key    [ENTRIES];
  logic signed [VAL_W-1:0] entry_value  [ENTRIES];
  logic [RANK_W-1:0]       recency_rank [ENTRIES];
  logic [CNT_W-1:0]        entry_count;

  // input register
  logic                    in_full;
  logic                    in_cmd;
  logic signed [KEY_W-1:0] in_key;
  logic signed [VAL_W-1:0] in_value;

  // output register
  logic                    out_full;
  logic                    out_hit;
  logic signed [VAL_W-1:0] out_read_value;
  logic                    out_evicted;
  logic signed [KEY_W-1:0] out_evicted_key;

  // lookup and replacement decisions
  logic                    advance;
  logic [ENTRIES-1:0]      match_oh;
  logic [ENTRIES-1:0]      victim_oh;
  logic [ENTRIES-1:0]      free_oh;
  logic [ENTRIES-1:0]      slot_oh;
  logic                    hit_any;
  logic signed [VAL_W-1:0] hit_value;
  logic [RANK_W-1:0]       hit_rank;
  logic signed [KEY_W-1:0] victim_key;
  logic [RANK_W-1:0]       lru_rank;
  logic [LIM_W-1:0]        cap_ext;
  logic [LIM_W-1:0]        limit;
  logic                    store_full;
  logic                    is_put;
  logic                    do_evict;
  logic                    do_insert;
  logic                    touch;

  // the stage moves on when the output register is empty or being emptied,
  // so a new word is taken even while a finished response waits
  assign advance   = in_full && (!out_full || rsp.ready);
  assign req.ready = !in_full || advance;

  // parallel key compare; keys are unique among valid entries
  always_comb begin
    hit_value = '0;
    hit_rank  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_oh[i] = entry_valid[i] && (entry_key[i] == in_key);
      if (match_oh[i]) begin
        hit_value = hit_value | entry_value[i];
        hit_rank  = hit_rank | recency_rank[i];
      end
    end
    hit_any = |match_oh;
  end

  // least recent entry carries rank count-1 (ranks of valid entries are a permutation)
  assign lru_rank = RANK_W'(entry_count - CNT_W'(1));

  always_comb begin
    victim_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      victim_oh[i] = entry_valid[i] && (recency_rank[i] == lru_rank);
      if (victim_oh[i]) begin
        victim_key = victim_key | entry_key[i];
      end
    end
  end

  // lowest free slot: lowest clear bit of the valid vector
  assign free_oh = ~entry_valid & (entry_valid + ENTRIES'(1));

  // effective capacity, saturated to 1..ENTRIES
  assign cap_ext = LIM_W'(capacity);

  always_comb begin
    priority if (cap_ext == '0) begin
      limit = LIM_W'(1);
    end else if (cap_ext > LIM_W'(ENTRIES)) begin
      limit = LIM_W'(ENTRIES);
    end else begin
      limit = cap_ext;
    end
  end

  assign store_full = LIM_W'(entry_count) >= limit;
  assign is_put     = (in_cmd == CMD_PUT);
  assign do_evict   = is_put && !hit_any && store_full;
  assign do_insert  = is_put && !hit_any && !store_full;
  assign touch      = hit_any || is_put;

  // the one entry this word writes and makes most recent
  always_comb begin
    priority if (hit_any) begin
      slot_oh = match_oh;
    end else if (do_evict) begin
      slot_oh = victim_oh;
    end else if (do_insert) begin
      slot_oh = free_oh;
    end else begin
      slot_oh = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAPACITY_RST;
      entry_valid <= '0;
      entry_count <= '0;
      in_full     <= 1'b0;
      out_full    <= 1'b0;
    end else begin
      if (capacity_we) begin
        // a capacity write empties the store
        capacity    <= capacity_wdata;
        entry_valid <= '0;
        entry_count <= '0;
      end else if (advance && do_insert) begin
        entry_valid <= entry_valid | free_oh;
        entry_count <= entry_count + CNT_W'(1);
      end

      if (req.valid && req.ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end

      if (advance) begin
        out_full <= 1'b1;
      end else if (rsp.ready) begin
        out_full <= 1'b0;
      end
    end
  end

  // input payload
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_cmd   <= req.cmd;
      in_key   <= req.key;
      in_value <= req.value;
    end
  end

  // entry words and ranks; only valid entries are ever read
  always_ff @(posedge clk) begin
    if (advance && touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_oh[i]) begin
          if (is_put) begin
            entry_value[i] <= in_value;
          end
          if (!hit_any) begin
            entry_key[i] <= in_key;
          end
          recency_rank[i] <= '0;
        end else if (entry_valid[i] && (!hit_any || recency_rank[i] < hit_rank)) begin
          // on a put miss every other valid entry ages; on a hit only the more recent ones
          recency_rank[i] <= recency_rank[i] + RANK_W'(1);
        end
      end
    end
  end

  // response payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_hit         <= hit_any;
      out_read_value  <= (hit_any && !is_put) ? hit_value : MISS_VALUE;
      out_evicted     <= do_evict;
      out_evicted_key <= do_evict ? victim_key : '0;
    end
  end

  assign rsp.valid       = out_full;
  assign rsp.hit         = out_hit;
  assign rsp.read_value  = out_read_value;
  assign rsp.evicted     = out_evicted;
  assign rsp.evicted_key = out_evicted_key;

  // checks

  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    in_full |-> $onehot0(match_oh))
    else $error("key matches more than one valid entry");

  a_count_tracks_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(entry_count))
    else $error("entry count out of step with valid bits");

  a_single_victim: assert property (@(posedge clk) disable iff (rst)
    (in_full && do_evict) |-> $onehot(victim_oh))
    else $error("no unique least recent entry on eviction");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_full |-> !(out_hit && out_evicted))
    else $error("response reports both hit and eviction");

endmodule

// ----- dv/lru_key_value_cache_test.sv -----
// self-checking testbench for the lru key-value cache: directed rows, then random phases
module lru_key_value_cache_test;
  import lrukv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES        = ENTRIES_DEF;
  localparam int RESET_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off in the pressure phase
  localparam int DRAIN_CYCLES   = 8;     // margin for stray words
  localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles before giving up
  localparam int PHASES         = 10;
  localparam int PHASE_WORDS    = 143;

  // expected contents of one response word
  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } access_result_t;

  // one row of the directed part: either a capacity write or a request word,
  // the latter optionally carrying a result typed in by hand
  typedef struct {
    logic             is_cap_write;
    logic [CAP_W-1:0] cap;
    logic             cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             typed;
    access_result_t   want;
  } stim_row_t;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

  logic             clk;
  logic             rst;
  logic             capacity_we;
  logic [CAP_W-1:0] capacity_wdata;

  lrukv_req_if req ();
  lrukv_rsp_if rsp ();

  lru_key_value_cache #(.ENTRIES(ENTRIES)) i_dut (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .rsp            (rsp),
    .capacity_we    (capacity_we),
    .capacity_wdata (capacity_wdata)
  );

  // ---------------------------------------------------------------------------
  // cache predictor: its own copy of the entries, their ages and the capacity
  // ---------------------------------------------------------------------------
  logic             slot_used [ENTRIES];
  logic [KEY_W-1:0] slot_key  [ENTRIES];
  logic [VAL_W-1:0] slot_val  [ENTRIES];
  int unsigned      slot_age  [ENTRIES];  // 0 is most recent
  int unsigned      used_count;
  logic [CAP_W-1:0] cap_reg;

  access_result_t   pending_results [$];  // responses still owed by the block
  int               mismatch_count = 0;
  int               src_pct = 0;          // chance in percent of an idle sender cycle
  int               snk_pct = 0;          // chance in percent of a stalled receiver cycle
  logic             hold_off_req = 1'b0;  // asks the receiver side for a long hold-off
  int               quiet_cycles;
  stim_row_t        stim_rows [$];

  function automatic void empty_store();
    for (int i = 0; i < ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_age[i]  = 0;
    end
    used_count = 0;
  endfunction

  // capacity in force: zero acts as one, anything above the entry count saturates
  function automatic int unsigned cap_limit();
    int unsigned c;
    c = cap_reg;
    if (c < 1) c = 1;
    if (c > ENTRIES) c = ENTRIES;
    return c;
  endfunction

  // make slot s most recent; only entries younger than the given age grow older
  function automatic void promote(int s, int unsigned above);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_used[i] && i != s && slot_age[i] < above) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic access_result_t cache_access(logic cmd, logic [KEY_W-1:0] key,
                                                  logic [VAL_W-1:0] value);
    access_result_t res;
    int             found;
    int             slot;
    int unsigned    worst;
    res.hit         = 1'b0;
    res.read_value  = MISS_VALUE;
    res.evicted     = 1'b0;
    res.evicted_key = '0;
    found           = -1;
    slot            = -1;
    worst           = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (found < 0 && slot_used[i] && slot_key[i] == key) found = i;
    if (found >= 0) begin
      res.hit = 1'b1;
      if (cmd == CMD_GET) res.read_value = slot_val[found];
      else slot_val[found] = value;
      promote(found, slot_age[found]);
    end else if (cmd == CMD_PUT) begin
      if (used_count >= cap_limit()) begin
        // full: the oldest entry gives up its slot, last one wins on a tie
        for (int i = 0; i < ENTRIES; i++)
          if (slot_used[i] && (slot < 0 || slot_age[i] >= worst)) begin
            slot  = i;
            worst = slot_age[i];
          end
        if (slot >= 0) begin
          res.evicted     = 1'b1;
          res.evicted_key = slot_key[slot];
          slot_key[slot]  = key;
          slot_val[slot]  = value;
          promote(slot, worst);
        end
      end else begin
        for (int i = 0; i < ENTRIES; i++)
          if (slot < 0 && !slot_used[i]) slot = i;
        if (slot >= 0) begin
          slot_used[slot] = 1'b1;
          slot_key[slot]  = key;
          slot_val[slot]  = value;
          promote(slot, ENTRIES + 1);
          used_count++;
        end
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // directed rows
  // ---------------------------------------------------------------------------
  function automatic void add_word(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    stim_row_t r;
    r.is_cap_write = 1'b0;
    r.cap          = '0;
    r.cmd          = cmd;
    r.key          = key;
    r.value        = value;
    r.typed        = 1'b0;
    r.want         = '0;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_known(logic cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value,
                                    logic hit, logic [VAL_W-1:0] rd, logic ev,
                                    logic [KEY_W-1:0] evk);
    stim_row_t r;
    r.is_cap_write     = 1'b0;
    r.cap              = '0;
    r.cmd              = cmd;
    r.key              = key;
    r.value            = value;
    r.typed            = 1'b1;
    r.want.hit         = hit;
    r.want.read_value  = rd;
    r.want.evicted     = ev;
    r.want.evicted_key = evk;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_cap(logic [CAP_W-1:0] cap);
    stim_row_t r;
    r.is_cap_write = 1'b1;
    r.cap          = cap;
    r.cmd          = CMD_GET;
    r.key          = '0;
    r.value        = '0;
    r.typed        = 1'b0;
    r.want         = '0;
    stim_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // clock, mismatch reporting
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one request word, with random idle cycles ahead of it, and log what it owes
  task automatic push_request(stim_row_t row);
    access_result_t want;
    while ($urandom_range(99) < src_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd   <= row.cmd;
    req.key   <= row.key;
    req.value <= row.value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    // taken at this edge: the predictor always runs so that its state keeps up
    want = cache_access(row.cmd, row.key, row.value);
    if (row.typed) want = row.want;
    pending_results.push_back(want);
  endtask

  // capacity write, only once the block has handed back every word it owes
  task automatic program_capacity(logic [CAP_W-1:0] cap);
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    capacity_we    <= 1'b1;
    capacity_wdata <= cap;
    @(posedge clk);
    capacity_we <= 1'b0;
    cap_reg = cap;
    empty_store();  // every write empties the store
  endtask

  // one random phase: keys mostly from a small pool sized to the capacity so that
  // hits, updates and evictions are common; the rest are extremes and noise
  task automatic run_phase(logic [CAP_W-1:0] cap, idle_mode_t mode, bit pressure);
    logic [KEY_W-1:0] key_pool [$];
    stim_row_t        r;
    int               pool_n;
    int               pick;
    program_capacity(cap);
    case (mode)
      IDLE_NONE: begin src_pct = 0;  snk_pct = 0;  end
      IDLE_SRC:  begin src_pct = 69; snk_pct = 0;  end
      IDLE_SNK:  begin src_pct = 0;  snk_pct = 69; end
      default:   begin src_pct = 30; snk_pct = 30; end
    endcase
    pool_n = cap_limit() + 1 + $urandom_range(4);
    for (int i = 0; i < pool_n; i++) key_pool.push_back($urandom);
    if (pressure) hold_off_req = 1'b1;
    for (int n = 0; n < PHASE_WORDS; n++) begin
      r.is_cap_write = 1'b0;
      r.cap          = '0;
      r.typed        = 1'b0;
      r.want         = '0;
      r.cmd          = ($urandom_range(99) < 55) ? CMD_PUT : CMD_GET;
      r.value        = $urandom;
      pick           = $urandom_range(99);
      if (pick < 85) r.key = key_pool[$urandom_range(pool_n - 1)];
      else if (pick < 90) begin
        case ($urandom_range(3))
          0:       r.key = 32'h8000_0000;
          1:       r.key = 32'h7fff_ffff;
          2:       r.key = '0;
          default: r.key = '1;
        endcase
      end else r.key = $urandom;
      push_request(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stalls, and one long hold-off so the input side backs up
  // ---------------------------------------------------------------------------
  initial begin : sink_side
    int hold_left;
    hold_left = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_left    = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp.ready <= ($urandom_range(99) >= snk_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // response checking, field by field against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_words
    access_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("response word with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (rsp.hit !== want.hit)
          report_mismatch($sformatf("hit got %b expected %b", rsp.hit, want.hit));
        if (rsp.read_value !== want.read_value)
          report_mismatch($sformatf("read_value got %h expected %h",
                                    rsp.read_value, want.read_value));
        if (rsp.evicted !== want.evicted)
          report_mismatch($sformatf("evicted got %b expected %b", rsp.evicted, want.evicted));
        if (rsp.evicted_key !== want.evicted_key)
          report_mismatch($sformatf("evicted_key got %h expected %h",
                                    rsp.evicted_key, want.evicted_key));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without a word moving on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("lru_key_value_cache test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    logic [CAP_W-1:0] phase_caps [PHASES];
    logic [CAP_W-1:0] cap;
    phase_caps = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd3, 5'd8, 5'd2, 5'd4, 5'd5};

    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.cmd        <= CMD_GET;
    req.key        <= '0;
    req.value      <= '0;
    capacity_we    <= 1'b0;
    capacity_wdata <= '0;
    quiet_cycles   <= 0;
    cap_reg = CAPACITY_RST;
    empty_store();

    // reset-value capacity: misses on an empty store, extreme keys and values
    add_known(CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, MISS_VALUE, 1'b0, '0);
    add_known(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff, 1'b0, MISS_VALUE, 1'b0, '0);
    add_known(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000, 1'b0, MISS_VALUE, 1'b0, '0);
    add_known(CMD_PUT, 32'h0000_0000, 32'h0000_0000, 1'b0, MISS_VALUE, 1'b0, '0);
    add_known(CMD_PUT, 32'hffff_ffff, 32'hffff_ffff, 1'b0, MISS_VALUE, 1'b0, '0);
    add_known(CMD_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, 32'h7fff_ffff, 1'b0, '0);
    add_known(CMD_GET, 32'h7fff_ffff, 32'h0000_0000, 1'b1, 32'h8000_0000, 1'b0, '0);
    // put that hits: value overwritten, read_value still the miss value
    add_known(CMD_PUT, 32'h0000_0000, 32'h5555_aaaa, 1'b1, MISS_VALUE, 1'b0, '0);
    add_known(CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h5555_aaaa, 1'b0, '0);
    add_known(CMD_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, MISS_VALUE, 1'b0, '0);
    // get hit on a stored all-ones value; the value field of a get is ignored
    add_known(CMD_GET, 32'hffff_ffff, 32'h1234_5678, 1'b1, MISS_VALUE, 1'b0, '0);
    // capacity zero acts as one: the second put evicts the first
    add_cap(5'd0);
    add_known(CMD_PUT, 32'h0000_0005, 32'h0000_0032, 1'b0, MISS_VALUE, 1'b0, '0);
    add_known(CMD_PUT, 32'h0000_0006, 32'h0000_003c, 1'b0, MISS_VALUE, 1'b1, 32'h0000_0005);
    add_known(CMD_GET, 32'h0000_0005, 32'h0000_0000, 1'b0, MISS_VALUE, 1'b0, '0);
    add_known(CMD_GET, 32'h0000_0006, 32'h0000_0000, 1'b1, 32'h0000_003c, 1'b0, '0);
    // capacity two: a get refreshes the older entry, so the other one goes
    add_cap(5'd2);
    add_word(CMD_PUT, 32'h0000_000a, 32'h0000_0001);
    add_word(CMD_PUT, 32'h0000_000b, 32'h0000_0002);
    add_word(CMD_GET, 32'h0000_000a, 32'h0000_0000);
    add_word(CMD_PUT, 32'h0000_000c, 32'h0000_0003);
    add_word(CMD_GET, 32'h0000_000b, 32'h0000_0000);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cap_write) program_capacity(stim_rows[i].cap);
      else push_request(stim_rows[i]);
    end

    // random phases cycle through the idle modes; phase four runs the hold-off
    for (int p = 0; p < PHASES; p++) begin
      cap = (p == 8) ? CAP_W'($urandom_range(31)) : phase_caps[p];
      run_phase(cap, idle_mode_t'(p % 4), p == 4);
    end

    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("lru_key_value_cache test passed");
    end else begin
      $display("lru_key_value_cache test failed");
    end
    $finish;
  end

endmodule
